### rtl/bfa_pkg.sv
// Shared widths, codes and defaults for the bitmap frame allocator.
package bfa_pkg;

  localparam int FRAME_W        = 12;
  localparam int WORD_W         = 32;
  localparam int POS_W          = 5;
  localparam int BITMAP_WORDS   = 128;
  localparam int BITMAP_BITS    = BITMAP_WORDS * WORD_W;
  localparam int NUM_FRAMES_DEF = 4096;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_FRAME = 1'b1;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } bfa_ffz_t;

endpackage

### rtl/bfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bfa_ffz.sv
// Find-first-zero unit: lowest clear bit of one bitmap word.
module bfa_ffz
  import bfa_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  output bfa_ffz_t          res
);

  always_comb begin
    res.found = 1'b0;
    res.pos   = '0;
    // Walk from the top so the lowest clear bit wins.
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res.found = 1'b1;
        res.pos   = POS_W'(i);
      end
    end
  end

endmodule

### rtl/bitmap_frame_allocator_top.sv
// First-fit page-frame allocator: used/free bitmap in RAM, scanned one word per cycle.
// Allocate from an empty entry: scans words in order, checked by the single find-first-zero unit
// on the RAM read port. Free of a managed frame: read, modify-write, result.
// Other requests go straight from acceptance to the result.
// One request at a time. A finished result waits in the output register while the next is taken.
// Reset (synchronous, rst_n low) marks every bitmap row invalid, which reads as all frames free.
module bitmap_frame_allocator_top
  import bfa_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [FRAME_W-1:0] in_current_frame,
  input  logic               in_is_kernel,
  input  logic               in_is_writeable,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FRAME_W-1:0] out_frame,
  output logic               out_present,
  output logic               out_writeable,
  output logic               out_user_mode,
  output logic               out_updated,
  output logic               out_status
);

  localparam int LIMIT     = (NUM_FRAMES < BITMAP_BITS) ? NUM_FRAMES : BITMAP_BITS;
  localparam int NWORDS    = (LIMIT + WORD_W - 1) / WORD_W;
  localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int LAST_BITS = LIMIT - (NWORDS - 1) * WORD_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);
  localparam logic [WORD_W-1:0] TAIL_FILL = (LAST_BITS == WORD_W) ? '0 :
      ~((WORD_W'(1) << LAST_BITS) - WORD_W'(1));
  localparam logic [FRAME_W:0] LIMIT_X = (FRAME_W + 1)'(LIMIT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE_WR,
    ST_RESP
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       chk_r, chk_nxt;
  logic [NWORDS-1:0]   row_valid_r, row_valid_nxt;
  logic                rd_valid_r;
  logic [FRAME_W-1:0]  req_frame_r, req_frame_nxt;
  logic                req_kern_r, req_kern_nxt;
  logic                req_wr_r, req_wr_nxt;

  logic [FRAME_W-1:0]  res_frame_r, res_frame_nxt;
  logic                res_present_r, res_present_nxt;
  logic                res_wr_r, res_wr_nxt;
  logic                res_user_r, res_user_nxt;
  logic                res_upd_r, res_upd_nxt;
  logic                res_status_r, res_status_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0]  out_frame_r, out_frame_nxt;
  logic                out_present_r, out_present_nxt;
  logic                out_wr_r, out_wr_nxt;
  logic                out_user_r, out_user_nxt;
  logic                out_upd_r, out_upd_nxt;
  logic                out_status_r, out_status_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_W-1:0]   ram_q;
  logic [WORD_W-1:0]   cur_word;
  logic [WORD_W-1:0]   scan_word;
  bfa_ffz_t            ffz;
  logic                in_fire;
  logic                can_emit;

  bfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS),
    .AW    (AW)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  bfa_ffz u_ffz (
    .word (scan_word),
    .res  (ffz)
  );

  // Rows never written since reset read as all free.
  assign cur_word  = rd_valid_r ? ram_q : '0;
  assign scan_word = cur_word | ((chk_r == LAST_WORD) ? TAIL_FILL : '0);

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign can_emit = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt       = state_r;
    chk_nxt         = chk_r;
    row_valid_nxt   = row_valid_r;
    req_frame_nxt   = req_frame_r;
    req_kern_nxt    = req_kern_r;
    req_wr_nxt      = req_wr_r;
    res_frame_nxt   = res_frame_r;
    res_present_nxt = res_present_r;
    res_wr_nxt      = res_wr_r;
    res_user_nxt    = res_user_r;
    res_upd_nxt     = res_upd_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_frame_nxt   = out_frame_r;
    out_present_nxt = out_present_r;
    out_wr_nxt      = out_wr_r;
    out_user_nxt    = out_user_r;
    out_upd_nxt     = out_upd_r;
    out_status_nxt  = out_status_r;
    ram_we          = 1'b0;
    ram_waddr       = chk_r;
    ram_wdata       = '0;
    ram_raddr       = chk_r;

    unique case (state_r)
      ST_IDLE: begin
        ram_raddr = AW'(in_current_frame[FRAME_W-1:POS_W]);
        if (in_fire) begin
          req_frame_nxt   = in_current_frame;
          req_kern_nxt    = in_is_kernel;
          req_wr_nxt      = in_is_writeable;
          res_frame_nxt   = '0;
          res_present_nxt = 1'b0;
          res_wr_nxt      = 1'b0;
          res_user_nxt    = 1'b0;
          res_upd_nxt     = 1'b0;
          res_status_nxt  = STATUS_OK;
          state_nxt       = ST_RESP;
          if (in_op == OP_ALLOC) begin
            if (in_current_frame != '0) begin
              res_frame_nxt = in_current_frame;
            end else begin
              ram_raddr = '0;
              chk_nxt   = '0;
              state_nxt = ST_SCAN;
            end
          end else if (in_current_frame != '0) begin
            res_upd_nxt = 1'b1;
            if ({1'b0, in_current_frame} < LIMIT_X) begin
              state_nxt = ST_FREE_WR;
            end
          end
        end
      end

      ST_SCAN: begin
        // Read of the next word overlaps the check of the current one.
        ram_raddr = (chk_r == LAST_WORD) ? chk_r : chk_r + AW'(1);
        if (ffz.found) begin
          ram_we          = 1'b1;
          ram_waddr       = chk_r;
          ram_wdata       = cur_word | (WORD_W'(1) << ffz.pos);
          row_valid_nxt[chk_r] = 1'b1;
          res_frame_nxt   = FRAME_W'({chk_r, ffz.pos});
          res_present_nxt = 1'b1;
          res_wr_nxt      = req_wr_r;
          res_user_nxt    = !req_kern_r;
          res_upd_nxt     = 1'b1;
          state_nxt       = ST_RESP;
        end else if (chk_r == LAST_WORD) begin
          res_status_nxt = STATUS_NO_FRAME;
          state_nxt      = ST_RESP;
        end else begin
          chk_nxt = chk_r + AW'(1);
        end
      end

      ST_FREE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(req_frame_r[FRAME_W-1:POS_W]);
        ram_wdata = cur_word & ~(WORD_W'(1) << req_frame_r[POS_W-1:0]);
        row_valid_nxt[ram_waddr] = 1'b1;
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (can_emit) begin
          out_valid_nxt   = 1'b1;
          out_frame_nxt   = res_frame_r;
          out_present_nxt = res_present_r;
          out_wr_nxt      = res_wr_r;
          out_user_nxt    = res_user_r;
          out_upd_nxt     = res_upd_r;
          out_status_nxt  = res_status_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_valid_r <= row_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_valid_r    <= row_valid_r[ram_raddr];
    chk_r         <= chk_nxt;
    req_frame_r   <= req_frame_nxt;
    req_kern_r    <= req_kern_nxt;
    req_wr_r      <= req_wr_nxt;
    res_frame_r   <= res_frame_nxt;
    res_present_r <= res_present_nxt;
    res_wr_r      <= res_wr_nxt;
    res_user_r    <= res_user_nxt;
    res_upd_r     <= res_upd_nxt;
    res_status_r  <= res_status_nxt;
    out_frame_r   <= out_frame_nxt;
    out_present_r <= out_present_nxt;
    out_wr_r      <= out_wr_nxt;
    out_user_r    <= out_user_nxt;
    out_upd_r     <= out_upd_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_frame     = out_frame_r;
  assign out_present   = out_present_r;
  assign out_writeable = out_wr_r;
  assign out_user_mode = out_user_r;
  assign out_updated   = out_upd_r;
  assign out_status    = out_status_r;

endmodule

### bench/tb_bitmap_frame_allocator_top.sv
// Self-checking testbench for the bitmap frame allocator: random and directed requests.
module tb_bitmap_frame_allocator_top;
  import bfa_pkg::*;

  localparam int DUT_FRAMES = NUM_FRAMES_DEF;
  localparam int MANAGED    = (DUT_FRAMES < BITMAP_BITS) ? DUT_FRAMES : BITMAP_BITS;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               writeable;
    logic               user_mode;
    logic               updated;
    logic               status;
  } alloc_result_t;

  class frame_alloc_scoreboard;
    bit [BITMAP_BITS-1:0] used_map;
    int                   used_count;
    int                   mismatches;
    int                   results_seen;
    alloc_result_t        expected_results[$];

    task report_mismatch(string msg);
      $display("ERROR: result %0d: %s", results_seen, msg);
      mismatches++;
    endtask

    // Updates the frame map for an accepted request and queues the result it must give.
    function alloc_result_t predict_request(logic op, logic [FRAME_W-1:0] cur, logic kern,
                                            logic wr);
      alloc_result_t r;
      int            idx;
      r   = '0;
      idx = -1;
      if (op == OP_ALLOC) begin
        if (cur != 0) begin
          r.frame = cur;
        end else begin
          for (int i = 0; i < MANAGED; i++) begin
            if (!used_map[i]) begin
              idx = i;
              break;
            end
          end
          if (idx >= 0) begin
            used_map[idx] = 1'b1;
            used_count++;
            r.frame     = idx[FRAME_W-1:0];
            r.present   = 1'b1;
            r.writeable = wr;
            r.user_mode = !kern;
            r.updated   = 1'b1;
            r.status    = STATUS_OK;
          end else begin
            r.status = STATUS_NO_FRAME;
          end
        end
      end else if (cur != 0) begin
        if (cur < MANAGED && used_map[cur]) begin
          used_map[cur] = 1'b0;
          used_count--;
        end
        r.updated = 1'b1;
      end
      expected_results.push_back(r);
      return r;
    endfunction

    task check_result(alloc_result_t got);
      alloc_result_t exp;
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with no request waiting for it");
      end else begin
        exp = expected_results.pop_front();
        if (got.frame !== exp.frame)
          report_mismatch($sformatf("frame got %0d expected %0d", got.frame, exp.frame));
        if (got.present !== exp.present)
          report_mismatch($sformatf("present got %b expected %b", got.present, exp.present));
        if (got.writeable !== exp.writeable)
          report_mismatch($sformatf("writeable got %b expected %b", got.writeable,
                                    exp.writeable));
        if (got.user_mode !== exp.user_mode)
          report_mismatch($sformatf("user_mode got %b expected %b", got.user_mode,
                                    exp.user_mode));
        if (got.updated !== exp.updated)
          report_mismatch($sformatf("updated got %b expected %b", got.updated, exp.updated));
        if (got.status !== exp.status)
          report_mismatch($sformatf("status got %b expected %b", got.status, exp.status));
      end
      results_seen++;
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_op;
  logic [FRAME_W-1:0] in_current_frame;
  logic               in_is_kernel;
  logic               in_is_writeable;
  logic               out_valid;
  logic               out_stall;
  logic [FRAME_W-1:0] out_frame;
  logic               out_present;
  logic               out_writeable;
  logic               out_user_mode;
  logic               out_updated;
  logic               out_status;

  frame_alloc_scoreboard sb = new();
  bit [FRAME_W-1:0]      held_frames[$];
  int                    tx_idle_pct;
  int                    rx_stall_pct;
  int                    rx_hold_left;

  bitmap_frame_allocator_top #(
    .NUM_FRAMES(DUT_FRAMES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_current_frame (in_current_frame),
    .in_is_kernel     (in_is_kernel),
    .in_is_writeable  (in_is_writeable),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame        (out_frame),
    .out_present      (out_present),
    .out_writeable    (out_writeable),
    .out_user_mode    (out_user_mode),
    .out_updated      (out_updated),
    .out_status       (out_status)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Receiver: random stalls, or a long hold-off counted down here when one is requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_stall <= 1'b1;
        rx_hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    alloc_result_t got;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{frame: out_frame, present: out_present, writeable: out_writeable,
              user_mode: out_user_mode, updated: out_updated, status: out_status};
      sb.check_result(got);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_request(logic op, logic [FRAME_W-1:0] cur, logic kern, logic wr);
    alloc_result_t res;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_current_frame <= cur;
    in_is_kernel     <= kern;
    in_is_writeable  <= wr;
    do @(posedge clk); while (in_stall !== 1'b0);
    res = sb.predict_request(op, cur, kern, wr);
    // Track which frames are held so that most frees name a frame in use.
    // Frame 0 cannot be freed, since 0 in an entry means no frame.
    if (op == OP_ALLOC && res.updated && res.frame != 0) begin
      held_frames.push_back(res.frame);
    end else if (op == OP_FREE && cur != 0) begin
      for (int i = 0; i < held_frames.size(); i++) begin
        if (held_frames[i] == cur) begin
          held_frames.delete(i);
          break;
        end
      end
    end
    @(negedge clk);
  endtask

  task automatic random_request();
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < 55 || (pick < 85 && held_frames.size() == 0)) begin
      send_request(OP_ALLOC, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (pick < 85) begin
      k = $urandom_range(0, held_frames.size() - 1);
      send_request(OP_FREE, held_frames[k], 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    end else begin
      // Odd requests: an entry that already holds a frame, frees of nothing or of random frames.
      case (pick % 3)
        0: send_request(OP_ALLOC, FRAME_W'($urandom_range(0, 4095)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        1: send_request(OP_FREE, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        default: send_request(OP_FREE, FRAME_W'($urandom_range(0, 4095)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  // The sender drops valid first so that the last beat is not offered again.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_op            = OP_ALLOC;
    in_current_frame = '0;
    in_is_kernel     = 1'b0;
    in_is_writeable  = 1'b0;
    tx_idle_pct      = 0;
    rx_stall_pct     = 0;
    rx_hold_left     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every flag combination, entries already holding a frame, frees of frame 0,
    // of a free frame and of the top frame, and reuse of a freed frame.
    send_request(OP_ALLOC, 12'd0, 1'b0, 1'b0);
    send_request(OP_ALLOC, 12'd0, 1'b1, 1'b1);
    send_request(OP_ALLOC, 12'd0, 1'b0, 1'b1);
    send_request(OP_ALLOC, 12'd0, 1'b1, 1'b0);
    send_request(OP_ALLOC, 12'hFFF, 1'b1, 1'b1);
    send_request(OP_ALLOC, 12'd2, 1'b0, 1'b0);
    send_request(OP_FREE, 12'd0, 1'b1, 1'b1);
    send_request(OP_FREE, 12'd2, 1'b0, 1'b0);
    send_request(OP_FREE, 12'd2, 1'b1, 1'b1);
    send_request(OP_FREE, 12'hFFF, 1'b0, 1'b0);
    send_request(OP_ALLOC, 12'd0, 1'b1, 1'b1);
    send_request(OP_FREE, 12'd1, 1'b0, 1'b1);
    send_request(OP_ALLOC, 12'd0, 1'b0, 1'b1);
    send_request(OP_FREE, 12'h800, 1'b1, 1'b0);
    send_request(OP_ALLOC, 12'h555, 1'b0, 1'b1);
    send_request(OP_ALLOC, 12'hAAA, 1'b1, 1'b0);
    send_request(OP_FREE, 12'd3, 1'b0, 1'b0);
    send_request(OP_ALLOC, 12'd0, 1'b1, 1'b1);
    send_request(OP_ALLOC, 12'd0, 1'b0, 1'b0);
    send_request(OP_ALLOC, 12'd0, 1'b1, 1'b0);

    // The receiver holds off for a long stretch while requests keep coming.
    rx_hold_left = 500;
    repeat (30) random_request();
    wait_for_drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 75; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 75; end
        default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
      endcase
      repeat (350) random_request();
      wait_for_drain();
    end

    // A last random mix with light idling on both sides.
    tx_idle_pct  = 25;
    rx_stall_pct = 25;
    repeat (80) random_request();

    wait_for_drain();
    repeat (140) @(negedge clk);
    if (sb.mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20000000;
    $display("ERROR: run did not finish in time");
    $display("== FAIL ==");
    $finish;
  end

endmodule
